[src/iac_pkg.sv]
// Package for the intrusion alarm controller: widths, command and register
// codes, the one-hot mode type and its mapping to the reported state code.
// No dependencies.
`default_nettype none

package iac_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int DELAY_W       = 17;
    localparam int DEBOUNCE_W    = 16;
    localparam int CFG_W         = 17;
    localparam int CFG_IDX_W     = 2;
    localparam int FUNC_W        = 2;
    localparam int CODE_W        = 3;
    localparam int SENSOR_N      = 3;

    // command codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_POLL   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISARM = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd2;

    localparam logic [DELAY_W-1:0]    DELAY_LOW      = 17'd5000;
    localparam logic [DELAY_W-1:0]    DELAY_HIGH     = 17'd120000;
    localparam logic [DELAY_W-1:0]    DELAY_RESET    = 17'd30000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd200;

    // reported state codes
    localparam logic [CODE_W-1:0] CODE_DISARMED  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_EXIT      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ARMED     = 3'd2;
    localparam logic [CODE_W-1:0] CODE_ENTRY     = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TRIGGERED = 3'd4;

    // sensor bit positions in the alert mask
    localparam int SNS_MOTION = 0;
    localparam int SNS_DOOR   = 1;
    localparam int SNS_SHOCK  = 2;

    typedef enum logic [4:0] {
        MODE_DISARMED  = 5'b00001,
        MODE_EXIT      = 5'b00010,
        MODE_ARMED     = 5'b00100,
        MODE_ENTRY     = 5'b01000,
        MODE_TRIGGERED = 5'b10000
    } mode_t;

    function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
        logic [CODE_W-1:0] c;
        unique case (m)
            MODE_DISARMED:  c = CODE_DISARMED;
            MODE_EXIT:      c = CODE_EXIT;
            MODE_ARMED:     c = CODE_ARMED;
            MODE_ENTRY:     c = CODE_ENTRY;
            MODE_TRIGGERED: c = CODE_TRIGGERED;
            default:        c = CODE_DISARMED;
        endcase
        return c;
    endfunction

    function automatic logic delay_ok(input logic [DELAY_W-1:0] v);
        return (v >= DELAY_LOW) && (v <= DELAY_HIGH);
    endfunction

endpackage

`default_nettype wire

[src/iac_if.sv]
// Handshake interfaces of the intrusion alarm controller: command items in,
// status items out. Depends on iac_pkg.
`default_nettype none

interface iac_cmd_if
    import iac_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [TIME_BITS-1:0] now_ms;
    logic                 pir;
    logic                 reed;
    logic                 vibration;

    modport source (output valid, func, now_ms, pir, reed, vibration, input ready);
    modport sink   (input valid, func, now_ms, pir, reed, vibration, output ready);
endinterface

interface iac_status_if
    import iac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] alarm_state;
    logic              buzzer;
    logic              state_changed;
    logic [2:0]        alert_mask;
    logic              alarm_raised;

    modport source (output valid, alarm_state, buzzer, state_changed, alert_mask,
                    alarm_raised, input ready);
    modport sink   (input valid, alarm_state, buzzer, state_changed, alert_mask,
                    alarm_raised, output ready);
endinterface

`default_nettype wire

[src/iac_sensor.sv]
// One sensor channel: rising-edge detect with a debounce window measured on
// the wrapping timestamp. Depends on iac_pkg.
`default_nettype none

module iac_sensor
    import iac_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  update,
    input  wire logic                  level,
    input  wire logic [TIME_BITS-1:0]  now_ms,
    input  wire logic [DEBOUNCE_W-1:0] debounce_ms,
    output logic                       hit
);

    logic                 prev_reg;
    logic [TIME_BITS-1:0] accept_reg;
    logic [TIME_BITS-1:0] since;

    assign since = now_ms - accept_reg;
    assign hit   = level && !prev_reg && (since >= TIME_BITS'(debounce_ms));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= 1'b0;
            accept_reg <= '0;
        end
        else if (update)
        begin
            prev_reg <= level;
            if (hit)
            begin
                accept_reg <= now_ms;
            end
        end
    end

endmodule

`default_nettype wire

[src/intrusion_alarm_controller_unit.sv]
// Intrusion alarm controller: five-mode panel with entry and exit delays.
// Depends on iac_pkg, iac_cmd_if, iac_status_if and iac_sensor.
//
// Usage:
//   cmd carries one item per handshake: func (poll, arm, disarm), the
//   millisecond timestamp now_ms and the pir, reed and vibration levels.
//   status returns exactly one item per command item: mode after the item,
//   buzzer, state_changed, alert_mask and alarm_raised. Registers are written
//   through cfg_we / cfg_index / cfg_data only while idle, a duty of the user
//   unchecked by the block; out-of-range delays and unknown indexes are dropped.
// Timing:
//   An item is captured into the input register at acceptance and its result
//   is registered as it leaves that register, which raises status.valid. One item
//   per cycle is sustained with status.ready high; the mode and sensor state
//   update as the result register loads, which keeps back-to-back items exact.
// Stall:
//   While status.ready is low the result holds, one more item may wait in the
//   input register, and cmd.ready then drops until the result is taken.
// Reset:
//   Mode disarmed, both delays 30000 ms, debounce 200 ms, all times and
//   previous sensor levels zero, no item held.
`default_nettype none

module intrusion_alarm_controller_unit
    import iac_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    iac_cmd_if.sink                   cmd,
    iac_status_if.source              status,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int CMP_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

    // configuration
    logic [DELAY_W-1:0]    entry_delay_reg;
    logic [DELAY_W-1:0]    exit_delay_reg;
    logic [DEBOUNCE_W-1:0] debounce_reg;

    // input stage
    logic                 in_valid_reg;
    logic [FUNC_W-1:0]    func_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [SENSOR_N-1:0]  level_reg;

    // panel state
    mode_t                mode_reg;
    mode_t                mode_next;
    logic [TIME_BITS-1:0] delay_start_reg;
    logic [TIME_BITS-1:0] delay_start_next;

    // result stage
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    state_reg;
    logic                 buzzer_reg;
    logic                 changed_reg;
    logic [SENSOR_N-1:0]  alert_reg;
    logic                 raised_reg;

    logic                 advance;
    logic                 take;
    logic                 sense_en;
    logic [SENSOR_N-1:0]  hits;
    logic [SENSOR_N-1:0]  alerts;
    logic [TIME_BITS-1:0] delay_elapsed;
    logic                 exit_done;
    logic                 entry_done;

    assign advance    = in_valid_reg && (!out_valid_reg || status.ready);
    assign cmd.ready  = !in_valid_reg || advance;
    assign take       = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_delay_reg <= DELAY_RESET;
            exit_delay_reg  <= DELAY_RESET;
            debounce_reg    <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENTRY_DELAY:
                begin
                    if (delay_ok(cfg_data))
                    begin
                        entry_delay_reg <= cfg_data;
                    end
                end
                CFG_EXIT_DELAY:
                begin
                    if (delay_ok(cfg_data))
                    begin
                        exit_delay_reg <= cfg_data;
                    end
                end
                CFG_DEBOUNCE:
                begin
                    debounce_reg <= cfg_data[DEBOUNCE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg  <= cmd.func;
            now_reg   <= cmd.now_ms;
            level_reg <= {cmd.vibration, cmd.reed, cmd.pir};
        end
    end

    // sensors are only sampled by a poll in armed
    assign sense_en = advance && (func_reg == FUNC_POLL) && (mode_reg == MODE_ARMED);

    genvar s;
    generate
        for (s = 0; s < SENSOR_N; s++)
        begin : g_sensor
            iac_sensor #(
                .TIME_BITS (TIME_BITS)
            ) u_sensor (
                .clk         (clk),
                .rst_n       (rst_n),
                .update      (sense_en),
                .level       (level_reg[s]),
                .now_ms      (now_reg),
                .debounce_ms (debounce_reg),
                .hit         (hits[s])
            );
        end
    endgenerate

    assign delay_elapsed = now_reg - delay_start_reg;
    assign exit_done     = CMP_W'(delay_elapsed) >= CMP_W'(exit_delay_reg);
    assign entry_done    = CMP_W'(delay_elapsed) >= CMP_W'(entry_delay_reg);

    always_comb
    begin
        mode_next        = mode_reg;
        delay_start_next = delay_start_reg;
        alerts           = '0;
        priority if (func_reg == FUNC_DISARM)
        begin
            mode_next = MODE_DISARMED;
        end
        else if (func_reg == FUNC_ARM)
        begin
            if (mode_reg == MODE_DISARMED)
            begin
                mode_next        = MODE_EXIT;
                delay_start_next = now_reg;
            end
        end
        else if (func_reg == FUNC_POLL)
        begin
            unique case (mode_reg)
                MODE_EXIT:
                begin
                    if (exit_done)
                    begin
                        mode_next = MODE_ARMED;
                    end
                end
                MODE_ENTRY:
                begin
                    if (entry_done)
                    begin
                        mode_next = MODE_TRIGGERED;
                    end
                end
                MODE_ARMED:
                begin
                    alerts = hits;
                    if (hits != '0)
                    begin
                        mode_next        = MODE_ENTRY;
                        delay_start_next = now_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            // unused command code: no change
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DISARMED;
            delay_start_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            delay_start_reg <= delay_start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg   <= mode_code(mode_next);
            buzzer_reg  <= (mode_next == MODE_TRIGGERED);
            changed_reg <= (mode_next != mode_reg);
            alert_reg   <= alerts;
            raised_reg  <= (mode_next == MODE_TRIGGERED) && (mode_reg != MODE_TRIGGERED);
        end
    end

    assign status.valid         = out_valid_reg;
    assign status.alarm_state   = state_reg;
    assign status.buzzer        = buzzer_reg;
    assign status.state_changed = changed_reg;
    assign status.alert_mask    = alert_reg;
    assign status.alarm_raised  = raised_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for intrusion_alarm_controller_unit: drives command items,
// predicts each status item with a cycle-free panel model, and checks them in order.
// Depends on iac_pkg, the iac_cmd_if / iac_status_if interfaces and the unit.

module tb_top;
    import iac_pkg::*;

    localparam int LATENCY    = 2;
    localparam int STALL_MAX  = 13;
    localparam int WATCHDOG   = 4000;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [CODE_W-1:0] alarm_state;
        logic              buzzer;
        logic              state_changed;
        logic [2:0]        alert_mask;
        logic              alarm_raised;
    } status_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    iac_cmd_if    cmd_bus ();
    iac_status_if sts_bus ();

    intrusion_alarm_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus),
        .status    (sts_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // panel model state
    logic [CODE_W-1:0]     panel_mode;
    logic [31:0]           delay_t0;
    logic                  sns_prev [SENSOR_N];
    logic [31:0]           sns_accept [SENSOR_N];
    logic                  siren;
    logic [DELAY_W-1:0]    entry_dly;
    logic [DELAY_W-1:0]    exit_dly;
    logic [DEBOUNCE_W-1:0] debounce;

    status_t status_due [$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    int      items_sent = 0;
    int      gap_pct = 0;
    int      stall_pct = 0;
    bit      quiet = 0;

    function automatic void panel_reset();
        panel_mode = CODE_DISARMED;
        delay_t0   = '0;
        siren      = 1'b0;
        entry_dly  = DELAY_RESET;
        exit_dly   = DELAY_RESET;
        debounce   = DEBOUNCE_RESET;
        for (int s = 0; s < SENSOR_N; s++)
        begin
            sns_prev[s]   = 1'b0;
            sns_accept[s] = '0;
        end
    endfunction

    function automatic void panel_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] d);
        case (idx)
            CFG_ENTRY_DELAY: if (d >= DELAY_LOW && d <= DELAY_HIGH) entry_dly = d;
            CFG_EXIT_DELAY:  if (d >= DELAY_LOW && d <= DELAY_HIGH) exit_dly = d;
            CFG_DEBOUNCE:    debounce = d[DEBOUNCE_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances the panel by one command item and returns the status it reports.
    function automatic status_t panel_step(input logic [FUNC_W-1:0] fn,
                                           input logic [31:0] now,
                                           input logic [2:0] lvl);
        status_t           r;
        logic [CODE_W-1:0] old_mode;
        logic [2:0]        hits;
        logic [31:0]       span;
        old_mode = panel_mode;
        hits     = '0;
        case (fn)
            FUNC_DISARM:
            begin
                panel_mode = CODE_DISARMED;
                siren      = 1'b0;
            end
            FUNC_ARM:
            begin
                if (old_mode == CODE_DISARMED)
                begin
                    panel_mode = CODE_EXIT;
                    delay_t0   = now;
                end
            end
            FUNC_POLL:
            begin
                span = now - delay_t0;
                if (old_mode == CODE_EXIT)
                begin
                    if (span >= exit_dly)
                        panel_mode = CODE_ARMED;
                end
                else if (old_mode == CODE_ENTRY)
                begin
                    if (span >= entry_dly)
                    begin
                        panel_mode = CODE_TRIGGERED;
                        siren      = 1'b1;
                    end
                end
                else if (old_mode == CODE_ARMED)
                begin
                    // every sensor is checked, even after the first one fires
                    for (int s = 0; s < SENSOR_N; s++)
                    begin
                        span = now - sns_accept[s];
                        if (lvl[s] && !sns_prev[s] && span >= debounce)
                        begin
                            sns_accept[s] = now;
                            hits[s]       = 1'b1;
                        end
                        sns_prev[s] = lvl[s];
                    end
                    if (hits != 0)
                    begin
                        panel_mode = CODE_ENTRY;
                        delay_t0   = now;
                    end
                end
            end
            default: ;
        endcase
        r.alarm_state   = panel_mode;
        r.buzzer        = siren;
        r.state_changed = (panel_mode != old_mode);
        r.alert_mask    = hits;
        r.alarm_raised  = (panel_mode == CODE_TRIGGERED) && (old_mode != CODE_TRIGGERED);
        return r;
    endfunction

    // Prediction, checking and watchdog share one process so their order is fixed.
    always @(posedge clk)
    begin : monitor
        status_t want;
        bit      moved;
        if (rst_n === 1'b1)
        begin
            moved = 1'b0;
            if (cfg_we)
                panel_write(cfg_index, cfg_data);
            if (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1)
            begin
                status_due.push_back(panel_step(cmd_bus.func, cmd_bus.now_ms,
                    {cmd_bus.vibration, cmd_bus.reed, cmd_bus.pir}));
                moved = 1'b1;
            end
            if (sts_bus.valid === 1'b1 && sts_bus.ready === 1'b1)
            begin
                moved = 1'b1;
                if (status_due.size() == 0)
                begin
                    $error("status item with no command item waiting");
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (sts_bus.alarm_state !== want.alarm_state)
                    begin
                        $error("alarm_state: expected %0d, got %0d",
                               want.alarm_state, sts_bus.alarm_state);
                        mismatches++;
                    end
                    if (sts_bus.buzzer !== want.buzzer)
                    begin
                        $error("buzzer: expected %0d, got %0d", want.buzzer, sts_bus.buzzer);
                        mismatches++;
                    end
                    if (sts_bus.state_changed !== want.state_changed)
                    begin
                        $error("state_changed: expected %0d, got %0d",
                               want.state_changed, sts_bus.state_changed);
                        mismatches++;
                    end
                    if (sts_bus.alert_mask !== want.alert_mask)
                    begin
                        $error("alert_mask: expected %0d, got %0d",
                               want.alert_mask, sts_bus.alert_mask);
                        mismatches++;
                    end
                    if (sts_bus.alarm_raised !== want.alarm_raised)
                    begin
                        $error("alarm_raised: expected %0d, got %0d",
                               want.alarm_raised, sts_bus.alarm_raised);
                        mismatches++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // status back-pressure in random bursts
    initial
    begin : sink_pacing
        sts_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                sts_bus.ready <= 1'b0;
                repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
            end
            sts_bus.ready <= 1'b1;
        end
    end

    // Valid stays high after an item is taken; the next call either loads the
    // next item or drops valid for a gap, so nothing else may let time pass.
    task automatic send(input logic [FUNC_W-1:0] fn, input logic [31:0] now,
                        input logic [2:0] lvl);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(posedge clk);
        end
        cmd_bus.valid     <= 1'b1;
        cmd_bus.func      <= fn;
        cmd_bus.now_ms    <= now;
        cmd_bus.pir       <= lvl[SNS_MOTION];
        cmd_bus.reed      <= lvl[SNS_DOOR];
        cmd_bus.vibration <= lvl[SNS_SHOCK];
        do @(posedge clk); while (cmd_bus.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        do @(posedge clk); while (status_due.size() != 0);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // sensor levels biased low so rising edges are common
    function automatic logic [2:0] sensor_levels();
        return 3'($urandom_range(0, 7) & $urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] poll_hop();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return 32'(debounce);
            2:       return $urandom_range(0, debounce + 10);
            default: return $urandom_range(0, 200000);
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // One pass through the panel: disarm, arm, exit delay, armed polls, entry delay,
    // a little traffic while triggered, and usually a disarm.
    task automatic run_session();
        logic [31:0] t_arm;
        logic [31:0] t;
        if (!quiet)
        begin
            gap_pct   = pick_pct();
            stall_pct = pick_pct();
        end
        if ($urandom_range(0, 6) == 0)
            send(FUNC_W'($urandom_range(0, 3)), $urandom(), 3'($urandom_range(0, 7)));
        t = $urandom();
        send(FUNC_DISARM, t, sensor_levels());
        t_arm = t + $urandom_range(0, 1000);
        send(FUNC_ARM, t_arm, sensor_levels());
        repeat ($urandom_range(0, 2))
            send(FUNC_POLL, t_arm + $urandom_range(0, exit_dly - 1), sensor_levels());
        t = t_arm + exit_dly + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40));
        send(FUNC_POLL, t, sensor_levels());
        repeat ($urandom_range(1, 8))
        begin
            t += poll_hop();
            send(FUNC_POLL, t, sensor_levels());
        end
        repeat ($urandom_range(0, 2))
            send(FUNC_POLL, t + $urandom_range(0, entry_dly - 1), sensor_levels());
        t += entry_dly + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40));
        send(FUNC_POLL, t, sensor_levels());
        if ($urandom_range(0, 2) == 0)
            send(FUNC_W'($urandom_range(0, 3)), t + $urandom_range(0, 5000),
                 3'($urandom_range(0, 7)));
        if ($urandom_range(0, 3) != 0)
            send(FUNC_DISARM, t + $urandom_range(0, 5000), sensor_levels());
    endtask

    task automatic run_items(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            run_session();
    endtask

    task automatic test_directed();
        logic [31:0] t_arm;
        logic [31:0] t_hit;
        gap_pct   = 20;
        stall_pct = 20;
        send(FUNC_POLL, 32'd0, 3'b111);
        send(FUNC_UNUSED, 32'hFFFF_FFFF, 3'b111);
        send(FUNC_DISARM, 32'd5, 3'b000);
        t_arm = 32'hFFFF_F000;
        send(FUNC_ARM, t_arm, 3'b000);
        send(FUNC_ARM, t_arm + 16, 3'b000);              // already arming
        send(FUNC_POLL, 32'h0000_6000, 3'b111);          // exit delay ignores sensors
        send(FUNC_UNUSED, t_arm + 100, 3'b010);
        send(FUNC_POLL, t_arm + 29999, 3'b000);
        send(FUNC_POLL, t_arm + 30000, 3'b111);          // runs out across the wrap
        send(FUNC_POLL, t_arm + 30000, 3'b000);
        t_hit = t_arm + 30010;
        send(FUNC_POLL, t_hit, 3'b111);                  // every sensor rises in one poll
        send(FUNC_POLL, t_hit + 29999, 3'b000);
        send(FUNC_POLL, t_hit + 30000, 3'b000);          // siren on
        send(FUNC_POLL, t_hit + 30001, 3'b111);
        send(FUNC_DISARM, t_hit + 30002, 3'b000);
        send(FUNC_ARM, 32'd100000, 3'b000);
        send(FUNC_POLL, 32'd130000, 3'b111);
        send(FUNC_POLL, 32'd130001, 3'b000);
        // wrap back to just inside the debounce window, then exactly at its edge
        send(FUNC_POLL, t_hit + 199, 3'b111);
        send(FUNC_POLL, t_hit + 199, 3'b000);
        send(FUNC_POLL, t_hit + 200, 3'b111);
        send(FUNC_POLL, t_hit + 30200, 3'b000);
        send(FUNC_ARM, t_hit + 30300, 3'b000);           // ignored while triggered
        send(FUNC_DISARM, t_hit + 30400, 3'b000);
    endtask

    task automatic test_short_delays();
        write_reg(CFG_ENTRY_DELAY, DELAY_LOW);
        write_reg(CFG_EXIT_DELAY, DELAY_LOW);
        write_reg(CFG_DEBOUNCE, '0);
        run_items(350);
    endtask

    task automatic test_long_delays();
        write_reg(CFG_ENTRY_DELAY, DELAY_HIGH);
        write_reg(CFG_EXIT_DELAY, DELAY_HIGH);
        write_reg(CFG_DEBOUNCE, 17'h0FFFF);
        run_items(170);
        drain();                                          // hold off until all status is back
        run_items(180);
    endtask

    task automatic test_rejected_writes();
        write_reg(CFG_ENTRY_DELAY, 17'd20000);
        write_reg(CFG_EXIT_DELAY, 17'd8000);
        write_reg(CFG_ENTRY_DELAY, DELAY_LOW - 1);
        write_reg(CFG_EXIT_DELAY, DELAY_HIGH + 1);
        write_reg(CFG_ENTRY_DELAY, 17'h1FFFF);
        write_reg(CFG_EXIT_DELAY, 17'h00000);
        write_reg(CFG_DEBOUNCE, 17'h1FFFF);               // top bit dropped
        write_reg(CFG_DEBOUNCE, 17'h10064);
        write_reg(CFG_UNUSED, CFG_W'($urandom_range(0, 17'h1FFFF)));
        run_items(300);
    endtask

    task automatic test_random_settings();
        repeat (4)
        begin
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_ENTRY_DELAY, CFG_W'($urandom_range(0, 17'h1FFFF)));
            else
                write_reg(CFG_ENTRY_DELAY, CFG_W'($urandom_range(DELAY_LOW, DELAY_HIGH)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_EXIT_DELAY, CFG_W'($urandom_range(0, 17'h1FFFF)));
            else
                write_reg(CFG_EXIT_DELAY, CFG_W'($urandom_range(DELAY_LOW, DELAY_HIGH)));
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 17'h1FFFF)));
            else
                write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 2000)));
            run_items(150);
        end
    endtask

    task automatic test_back_to_back();
        quiet     = 1'b1;
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(CFG_ENTRY_DELAY, CFG_W'($urandom_range(DELAY_LOW, DELAY_HIGH)));
        write_reg(CFG_EXIT_DELAY, CFG_W'($urandom_range(DELAY_LOW, DELAY_HIGH)));
        write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 1000)));
        run_items(250);
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ENTRY_DELAY;
        cfg_data          <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.func      <= FUNC_POLL;
        cmd_bus.now_ms    <= '0;
        cmd_bus.pir       <= 1'b0;
        cmd_bus.reed      <= 1'b0;
        cmd_bus.vibration <= 1'b0;
        panel_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_short_delays();
        test_long_delays();
        test_rejected_writes();
        test_random_settings();
        test_back_to_back();

        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
